FILE: src/txrg_pkg.sv
// shared types and constants of the text character raster generator
package txrg_pkg;

    // commands carried by an input beat
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_GLYPH = 2'd2,
        CMD_FONT  = 2'd3
    } cmd_t;

    // fixed raster geometry
    localparam int LINES_PER_ROW = 8;
    localparam int SUB_W         = 3;
    localparam int GLYPH_BYTES   = 8;
    localparam int FONT_DEPTH    = 1024;
    localparam int FONT_AW       = 10;
    localparam int CODE_W        = 7;
    localparam logic [7:0] INVERT_MASK = 8'hff;

    // item leaving the character memory stage
    typedef struct packed {
        logic                valid;
        cmd_t                cmd;
        logic [9:0]          address;
        logic [7:0]          write_data;
        logic [SUB_W-1:0]    sub;
        logic [7:0]          scan_line;
        logic [4:0]          cell_column;
        logic                line_end;
        logic                frame_end;
    } cell_ctl_t;

    // finished pixel beat
    typedef struct packed {
        logic       valid;
        logic [7:0] pixels;
        logic [7:0] scan_line;
        logic [4:0] cell_column;
        logic       line_end;
        logic       frame_end;
    } pix_beat_t;

endpackage

FILE: src/txrg_char_mem.sv
// raster counters and character memory stage
module txrg_char_mem
    import txrg_pkg::*;
#(
    parameter int TEXT_COLUMNS = 32,
    parameter int TEXT_ROWS    = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            accept,
    input  logic [1:0]      command,
    input  logic [9:0]      address,
    input  logic [7:0]      write_data,
    output cell_ctl_t       cell_ctl,
    output logic [7:0]      char_data
);

    localparam int CHAR_DEPTH  = TEXT_COLUMNS * TEXT_ROWS;
    localparam int CA_W        = $clog2(CHAR_DEPTH);
    localparam int FRAME_LINES = TEXT_ROWS * LINES_PER_ROW;
    localparam int COL_W       = $clog2(TEXT_COLUMNS);
    localparam int LINE_W      = $clog2(FRAME_LINES);

    logic [7:0]        char_mem [CHAR_DEPTH];
    logic [7:0]        char_rd_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    cell_ctl_t         ctl_reg;
    cmd_t              cmd;
    logic              is_tick;
    logic              last_col;
    logic              last_line;
    logic [CA_W-1:0]   rd_addr;

    assign cmd       = cmd_t'(command);
    assign is_tick   = (cmd == CMD_TICK);
    assign last_col  = (col_reg == COL_W'(TEXT_COLUMNS - 1));
    assign last_line = (line_reg == LINE_W'(FRAME_LINES - 1));

    // cell address of the current raster position
    assign rd_addr = CA_W'(int'(line_reg[LINE_W-1:SUB_W]) * TEXT_COLUMNS + int'(col_reg));

    // raster position after a tick
    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept && is_tick)
        begin
            if (last_col)
            begin
                col_next  = '0;
                line_next = last_line ? '0 : line_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
            ctl_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            if (adv)
            begin
                ctl_reg.valid       <= accept;
                ctl_reg.cmd         <= cmd;
                ctl_reg.address     <= address;
                ctl_reg.write_data  <= write_data;
                ctl_reg.sub         <= line_reg[SUB_W-1:0];
                ctl_reg.scan_line   <= 8'(line_reg);
                ctl_reg.cell_column <= 5'(col_reg);
                ctl_reg.line_end    <= last_col;
                ctl_reg.frame_end   <= last_col && last_line;
            end
        end
    end

    // character memory, read and written only by the beat entering the pipeline
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_CHAR && 32'(address) < CHAR_DEPTH)
        begin
            char_mem[CA_W'(address)] <= write_data;
        end
        if (adv)
        begin
            char_rd_reg <= char_mem[rd_addr];
        end
    end

    assign cell_ctl  = ctl_reg;
    assign char_data = char_rd_reg;

endmodule

FILE: src/txrg_glyph_mem.sv
// glyph RAM and font store stage with pixel selection
module txrg_glyph_mem
    import txrg_pkg::*;
#(
    parameter int PROGRAMMABLE_GLYPHS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       glyph_en,
    input  cell_ctl_t  cell_ctl,
    input  logic [7:0] char_data,
    output pix_beat_t  pix_beat
);

    localparam int GLYPH_DEPTH = PROGRAMMABLE_GLYPHS * GLYPH_BYTES;
    localparam int GA_W        = $clog2(GLYPH_DEPTH);

    logic [7:0]        glyph_mem [GLYPH_DEPTH];
    logic [7:0]        font_mem  [FONT_DEPTH];
    logic [7:0]        glyph_rd_reg;
    logic [7:0]        font_rd_reg;
    logic [CODE_W-1:0] code;
    logic              attr;
    logic              use_glyph;
    logic [FONT_AW-1:0] glyph_row;
    logic              tick_valid;
    logic              use_glyph_reg;
    logic              attr_reg;
    pix_beat_t         beat_reg;

    // decode the cell code
    assign attr       = char_data[7];
    assign code       = char_data[CODE_W-1:0];
    assign use_glyph  = glyph_en && attr && (32'(code) < PROGRAMMABLE_GLYPHS);
    assign glyph_row  = {code, cell_ctl.sub};
    assign tick_valid = cell_ctl.valid && (cell_ctl.cmd == CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            use_glyph_reg <= 1'b0;
            attr_reg      <= 1'b0;
        end
        else if (adv)
        begin
            beat_reg.valid       <= tick_valid;
            beat_reg.pixels      <= '0;
            beat_reg.scan_line   <= cell_ctl.scan_line;
            beat_reg.cell_column <= cell_ctl.cell_column;
            beat_reg.line_end    <= cell_ctl.line_end;
            beat_reg.frame_end   <= cell_ctl.frame_end;
            use_glyph_reg        <= use_glyph;
            attr_reg             <= attr;
        end
    end

    // both stores are read and written by the beat at this stage only, so
    // writes stay in order with earlier ticks while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (adv && cell_ctl.valid && cell_ctl.cmd == CMD_GLYPH
            && 32'(cell_ctl.address) < GLYPH_DEPTH)
        begin
            glyph_mem[GA_W'(cell_ctl.address)] <= cell_ctl.write_data;
        end
        if (adv && cell_ctl.valid && cell_ctl.cmd == CMD_FONT)
        begin
            font_mem[cell_ctl.address] <= cell_ctl.write_data;
        end
        if (adv)
        begin
            glyph_rd_reg <= glyph_mem[GA_W'(glyph_row)];
            font_rd_reg  <= font_mem[glyph_row];
        end
    end

    // pick the glyph byte, invert attributed font bytes
    always_comb
    begin
        pix_beat = beat_reg;
        if (use_glyph_reg)
        begin
            pix_beat.pixels = glyph_rd_reg;
        end
        else
        begin
            pix_beat.pixels = font_rd_reg ^ (attr_reg ? INVERT_MASK : 8'h00);
        end
    end

endmodule

FILE: src/text_character_raster_generator.sv
// top level of the text character raster generator
// Accepts one command beat per cycle and returns one pixel beat per tick; writes
// return nothing. The pipeline is the character memory read, then the glyph RAM
// and font store read, then the output register, and it advances as a whole:
// while the output beat is stalled no new beat enters. Memories come out of reset
// undefined, with no clearing pass, and must be loaded before ticks read them.
// The configuration port is always ready.
module text_character_raster_generator
    import txrg_pkg::*;
#(
    parameter int TEXT_COLUMNS        = 32,
    parameter int TEXT_ROWS           = 24,
    parameter int PROGRAMMABLE_GLYPHS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    input  logic [9:0] address,
    input  logic [7:0] write_data,
    output logic       pix_valid,
    input  logic       pix_stall,
    output logic [7:0] pixels,
    output logic [7:0] scan_line,
    output logic [4:0] cell_column,
    output logic       line_end,
    output logic       frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       glyph_ram_enable
);

    localparam int FRAME_LINES = TEXT_ROWS * LINES_PER_ROW;

    logic       adv;
    logic       accept;
    logic       glyph_ram_enable_reg;
    cell_ctl_t  cell_ctl;
    logic [7:0] char_data;
    pix_beat_t  pix_beat;
    pix_beat_t  out_reg;

    // whole pipeline moves when the output register is free or being taken
    assign adv       = !out_reg.valid || !pix_stall;
    assign cmd_stall = !adv;
    assign accept    = cmd_valid && adv;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_ram_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            glyph_ram_enable_reg <= glyph_ram_enable;
        end
    end

    txrg_char_mem #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_char_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .accept     (accept),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .cell_ctl   (cell_ctl),
        .char_data  (char_data)
    );

    txrg_glyph_mem #(
        .PROGRAMMABLE_GLYPHS (PROGRAMMABLE_GLYPHS)
    ) u_glyph_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .glyph_en  (glyph_ram_enable_reg),
        .cell_ctl  (cell_ctl),
        .char_data (char_data),
        .pix_beat  (pix_beat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (adv)
        begin
            out_reg <= pix_beat;
        end
    end

    assign pix_valid   = out_reg.valid;
    assign pixels      = out_reg.pixels;
    assign scan_line   = out_reg.scan_line;
    assign cell_column = out_reg.cell_column;
    assign line_end    = out_reg.line_end;
    assign frame_end   = out_reg.frame_end;

    // frame end only on the last byte of the last line
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && frame_end) |-> (line_end && scan_line == 8'(FRAME_LINES - 1)))
        else $error("frame end away from the last byte of the frame");

    // line end only on the last column
    a_line_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && line_end) |-> (cell_column == 5'(TEXT_COLUMNS - 1)))
        else $error("line end away from the last column");

    // a beat waiting at the output stalls the input side
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_stall) |=> (pix_valid && (cmd_stall || !pix_stall)))
        else $error("output beat lost while stalled");

endmodule

FILE: bench/text_character_raster_generator_test.sv
// self-checking testbench for the text character raster generator
`timescale 1ns / 1ps

module text_character_raster_generator_test;
    import txrg_pkg::*;

    localparam int COLS        = 32;
    localparam int ROWS        = 24;
    localparam int GLYPHS      = 32;
    localparam int CHAR_DEPTH  = COLS * ROWS;
    localparam int GLYPH_DEPTH = GLYPHS * GLYPH_BYTES;
    localparam int FRAME_LINES = ROWS * LINES_PER_ROW;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 150;

    // one expected or observed pixel beat
    typedef struct packed {
        logic [7:0] pixels;
        logic [7:0] scan_line;
        logic [4:0] cell_column;
        logic       line_end;
        logic       frame_end;
    } raster_beat_t;

    // mirror of the screen memories and raster counters
    class raster_scoreboard;
        logic [7:0] char_mem[CHAR_DEPTH];
        logic [7:0] glyph_mem[GLYPH_DEPTH];
        logic [7:0] font_mem[FONT_DEPTH];
        bit char_set[CHAR_DEPTH];
        bit glyph_set[GLYPH_DEPTH];
        bit font_set[FONT_DEPTH];
        bit glyph_enable;
        int col_count;
        int line_count;
        raster_beat_t pending_pixels[$];
        int errors;
        int ticks;
        int writes;
        int beats_checked;
        int frame_wraps;

        // pixel byte of the cell under the raster counters
        function logic [7:0] raster_byte();
            int cell_at;
            int sub;
            int at;
            logic [7:0] char_code;
            logic [CODE_W-1:0] code;
            cell_at = (line_count / LINES_PER_ROW) * COLS + col_count;
            sub = line_count % LINES_PER_ROW;
            char_code = char_mem[cell_at];
            code = char_code[CODE_W-1:0];
            at = int'(code) * GLYPH_BYTES + sub;
            if (glyph_enable && char_code[7] && int'(code) < GLYPHS)
                return glyph_mem[at];
            return font_mem[at] ^ (char_code[7] ? INVERT_MASK : 8'h00);
        endfunction

        // accepted command beat: update memories or queue a pixel beat
        function void note_command(cmd_t cmd, logic [9:0] addr, logic [7:0] data);
            raster_beat_t beat;
            case (cmd)
                CMD_CHAR:
                begin
                    writes++;
                    if (addr < CHAR_DEPTH)
                    begin
                        char_mem[addr] = data;
                        char_set[addr] = 1'b1;
                    end
                end
                CMD_GLYPH:
                begin
                    writes++;
                    if (addr < GLYPH_DEPTH)
                    begin
                        glyph_mem[addr] = data;
                        glyph_set[addr] = 1'b1;
                    end
                end
                CMD_FONT:
                begin
                    writes++;
                    if (addr < FONT_DEPTH)
                    begin
                        font_mem[addr] = data;
                        font_set[addr] = 1'b1;
                    end
                end
                default:
                begin
                    ticks++;
                    beat.pixels = raster_byte();
                    beat.scan_line = 8'(line_count);
                    beat.cell_column = 5'(col_count);
                    beat.line_end = (col_count == COLS - 1);
                    beat.frame_end = beat.line_end && (line_count == FRAME_LINES - 1);
                    pending_pixels.push_back(beat);
                    if (beat.line_end)
                    begin
                        col_count = 0;
                        line_count = beat.frame_end ? 0 : line_count + 1;
                    end
                    else
                    begin
                        col_count++;
                    end
                    if (beat.frame_end)
                        frame_wraps++;
                end
            endcase
        endfunction

        // accepted pixel beat against the oldest expectation
        function void check_pixels(raster_beat_t got);
            raster_beat_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("pixel beat with nothing expected: pixels %0h line %0d column %0d",
                       got.pixels, got.scan_line, got.cell_column);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            beats_checked++;
            if (got.pixels !== want.pixels)
            begin
                $error("pixels expected %0h actual %0h", want.pixels, got.pixels);
                errors++;
            end
            if (got.scan_line !== want.scan_line)
            begin
                $error("scan_line expected %0d actual %0d", want.scan_line, got.scan_line);
                errors++;
            end
            if (got.cell_column !== want.cell_column)
            begin
                $error("cell_column expected %0d actual %0d", want.cell_column,
                       got.cell_column);
                errors++;
            end
            if (got.line_end !== want.line_end)
            begin
                $error("line_end expected %0b actual %0b", want.line_end, got.line_end);
                errors++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end expected %0b actual %0b", want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    logic [1:0] command;
    logic [9:0] address;
    logic [7:0] write_data;
    logic       pix_valid;
    logic       pix_stall;
    logic [7:0] pixels;
    logic [7:0] scan_line;
    logic [4:0] cell_column;
    logic       line_end;
    logic       frame_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       glyph_ram_enable;

    raster_scoreboard sb;
    int  cycle_count = 0;
    int  stall_left = 0;
    int  cfg_writes = 0;
    logic calm;

    text_character_raster_generator #(
        .TEXT_COLUMNS        (COLS),
        .TEXT_ROWS           (ROWS),
        .PROGRAMMABLE_GLYPHS (GLYPHS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .address          (address),
        .write_data       (write_data),
        .pix_valid        (pix_valid),
        .pix_stall        (pix_stall),
        .pixels           (pixels),
        .scan_line        (scan_line),
        .cell_column      (cell_column),
        .line_end         (line_end),
        .frame_end        (frame_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .glyph_ram_enable (glyph_ram_enable)
    );

    always #10 clk = ~clk;

    // quiet windows in which no new gaps or stalls begin on either side
    assign calm = ((cycle_count / 128) % 4) == 0;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 90)
            return $urandom_range(2, 3);
        return $urandom_range(8, 16);
    endfunction

    // random back pressure on the pixel side
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            pix_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            pix_stall <= 1'b1;
            stall_left = pick_idle_len() - 1;
        end
        else
        begin
            pix_stall <= 1'b0;
        end
    end

    // pixel beat monitor
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
            sb.check_pixels({pixels, scan_line, cell_column, line_end, frame_end});
    end

    // one command beat, with an optional gap ahead of it
    task automatic send_beat(cmd_t cmd, logic [9:0] addr, logic [7:0] data);
        int gap;
        gap = calm ? 0 : ($urandom_range(0, 99) < 55 ? 0 : pick_idle_len());
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        write_data <= data;
        do @(posedge clk); while (cmd_stall !== 1'b0);
        sb.note_command(cmd, addr, data);
    endtask

    // tick, loading first whatever entries the next cell reads that are still unwritten
    task automatic send_tick();
        int cell_at;
        int at;
        logic [7:0] char_code;
        cell_at = (sb.line_count / LINES_PER_ROW) * COLS + sb.col_count;
        if (!sb.char_set[cell_at])
            send_beat(CMD_CHAR, 10'(cell_at), 8'($urandom_range(0, 255)));
        char_code = sb.char_mem[cell_at];
        at = int'(char_code[CODE_W-1:0]) * GLYPH_BYTES + (sb.line_count % LINES_PER_ROW);
        if (!sb.font_set[at])
            send_beat(CMD_FONT, 10'(at), 8'($urandom_range(0, 255)));
        if (char_code[7] && int'(char_code[CODE_W-1:0]) < GLYPHS && !sb.glyph_set[at])
            send_beat(CMD_GLYPH, 10'(at), 8'($urandom_range(0, 255)));
        send_beat(CMD_TICK, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    endtask

    // random item: tick or memory write, writes mostly inside the memory
    task automatic send_random_item(int tick_pct);
        int depth;
        cmd_t cmd;
        logic [9:0] addr;
        if ($urandom_range(0, 99) < tick_pct)
        begin
            send_tick();
        end
        else
        begin
            cmd = cmd_t'($urandom_range(1, 3));
            depth = (cmd == CMD_CHAR) ? CHAR_DEPTH : (cmd == CMD_GLYPH) ? GLYPH_DEPTH
                                                                          : FONT_DEPTH;
            if ($urandom_range(0, 99) < 75)
                addr = 10'($urandom_range(0, depth - 1));
            else
                addr = 10'($urandom_range(0, 1023));
            send_beat(cmd, addr, 8'($urandom_range(0, 255)));
        end
    endtask

    // hold the sender until every pixel beat is back and the pipeline is empty
    task automatic drain_pipeline();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_glyph_enable(logic value);
        cfg_valid <= 1'b1;
        glyph_ram_enable <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.glyph_enable = value;
        cfg_writes++;
    endtask

    initial
    begin
        sb = new;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        command <= CMD_TICK;
        address <= '0;
        write_data <= '0;
        pix_stall <= 1'b0;
        cfg_valid <= 1'b0;
        glyph_ram_enable <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: code and address extremes, attribute and glyph range edges
        write_glyph_enable(1'b1);
        send_beat(CMD_CHAR, 10'd0, 8'h85);
        send_beat(CMD_CHAR, 10'd1, 8'h05);
        send_beat(CMD_CHAR, 10'd2, 8'hA0);
        send_beat(CMD_CHAR, 10'd3, 8'hFF);
        send_beat(CMD_CHAR, 10'd4, 8'h9F);
        send_beat(CMD_CHAR, 10'(CHAR_DEPTH - 1), 8'h00);
        send_beat(CMD_CHAR, 10'(CHAR_DEPTH), 8'h55);
        send_beat(CMD_CHAR, 10'd1023, 8'hFF);
        send_beat(CMD_GLYPH, 10'd40, 8'h81);
        send_beat(CMD_GLYPH, 10'd248, 8'h7E);
        send_beat(CMD_GLYPH, 10'(GLYPH_DEPTH - 1), 8'hFF);
        send_beat(CMD_GLYPH, 10'(GLYPH_DEPTH), 8'h00);
        send_beat(CMD_FONT, 10'd40, 8'h3C);
        send_beat(CMD_FONT, 10'd256, 8'hA5);
        send_beat(CMD_FONT, 10'd1016, 8'h00);
        send_beat(CMD_FONT, 10'd1023, 8'hFF);
        send_beat(CMD_FONT, 10'd0, 8'h00);
        repeat (5) send_tick();

        // attributed low code with the glyph RAM switched off
        drain_pipeline();
        write_glyph_enable(1'b0);
        send_beat(CMD_CHAR, 10'd5, 8'h85);
        send_tick();

        // random phases, each setting applied while idle
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            write_glyph_enable(phase == 0 ? 1'b1 : phase == 1 ? 1'b0
                                                             : 1'($urandom_range(0, 1)));
            repeat (PHASE_ITEMS) send_random_item(55);
        end

        // short mixed tail with the glyph RAM on
        drain_pipeline();
        write_glyph_enable(1'b1);
        repeat (40) send_random_item(60);

        drain_pipeline();
        if (sb.pending_pixels.size() != 0)
        begin
            $error("%0d pixel beats never arrived", sb.pending_pixels.size());
            sb.errors++;
        end
        $display("covered %0d ticks and %0d memory writes, %0d pixel beats checked",
                 sb.ticks, sb.writes, sb.beats_checked);
        $display("%0d frame wraps, %0d glyph enable writes", sb.frame_wraps, cfg_writes);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
src/txrg_pkg.sv
src/txrg_char_mem.sv
src/txrg_glyph_mem.sv
src/text_character_raster_generator.sv
bench/text_character_raster_generator_test.sv
